### rtl/int_to_decimal_ascii_macros.svh
// Assertion macros for the int_to_decimal_ascii checker.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ITDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ITDA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/itda_pkg.sv
// Shared types and constants for the decimal ASCII converter.
`timescale 1ns / 1ps
package itda_pkg;

    localparam int VALUE_IN_W  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_W      = 8;

    // digits of 2^VALUE_WIDTH - 1
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W       = NUM_DIGITS * 4;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic FUNC_SIGNED   = 1'b0;
    localparam logic FUNC_UNSIGNED = 1'b1;

    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } itda_job_t;

    typedef struct packed {
        logic      valid;
        itda_job_t job;
    } itda_push_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_SKIP,
        BK_SIGN,
        BK_EMIT
    } back_state_t;

endpackage

### rtl/itda_queue.sv
// Short job queue between the front classifier and the back converter.
`timescale 1ns / 1ps
module itda_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  itda_pkg::itda_push_t push,
    output logic                full,
    output logic                q_valid,
    output itda_pkg::itda_job_t q_job,
    input  logic                q_pop
);
    import itda_pkg::*;

    itda_job_t          mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

### rtl/itda_front.sv
// Input front end: accepts operands and forms sign and magnitude.
`timescale 1ns / 1ps
module itda_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [itda_pkg::VALUE_IN_W-1:0] value,
    input  logic                          func,
    input  logic                          q_full,
    output itda_pkg::itda_push_t          push
);
    import itda_pkg::*;

    logic [VALUE_WIDTH-1:0] v;
    logic                   neg;

    assign v   = value[VALUE_WIDTH-1:0];
    assign neg = (func == FUNC_SIGNED) && v[VALUE_WIDTH-1];

    assign in_ready      = !q_full;
    assign push.valid    = in_valid;
    assign push.job.neg  = neg;
    // most negative value wraps to 2^(W-1), which is its true magnitude
    assign push.job.mag  = neg ? (~v + 1'b1) : v;

endmodule

### rtl/itda_back.sv
// Back end: bit-serial binary to BCD, then one ASCII character per transfer.
`timescale 1ns / 1ps
module itda_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  itda_pkg::itda_job_t        q_job,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [itda_pkg::CHAR_W-1:0] ascii_char,
    output logic                       last
);
    import itda_pkg::*;

    back_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   final_digit;

    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign out_free    = !out_valid_reg || out_ready;
    assign final_digit = (cnt_reg == CNT_W'(NUM_DIGITS - 1));

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                            : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    bin_next   = q_job.mag;
                    neg_next   = q_job.neg;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = BK_CONV;
                end
            end
            BK_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = BK_SKIP;
                end
            end
            BK_SKIP:
            begin
                if (top_digit == 4'd0 && !final_digit)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? BK_SIGN : BK_EMIT;
                end
            end
            BK_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
                    last_next      = final_digit;
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next       = cnt_reg + 1'b1;
                    if (final_digit)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

endmodule

### rtl/int_to_decimal_ascii.sv
// Top level of the 32-bit integer to decimal ASCII converter.
//
// Input channel (in_valid/in_ready): one operand per transfer, value plus
// func (0 = signed, 1 = unsigned). A two-entry queue holds accepted operands,
// so in_ready stays high until two are waiting behind the one in progress.
// Output channel (out_valid/out_ready): one ASCII character per transfer,
// most significant digit first, '-' first for negative signed operands,
// last high on the final character. No leading zeros; zero gives "0".
// An operand taken from the queue goes first through the bit-serial
// binary to BCD shift, one operand bit per cycle, and then through the
// digit scan, one BCD digit per cycle while the receiver is ready, for
// zero skipping and output.
// A stalled receiver holds the current character in the output register
// and holds the digit scan; the input queue keeps accepting until full.
// Reset empties the queue, idles the converter and drops out_valid.
`timescale 1ns / 1ps
module int_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [itda_pkg::VALUE_IN_W-1:0] value,
    input  logic                          func,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [itda_pkg::CHAR_W-1:0]   ascii_char,
    output logic                          last
);
    import itda_pkg::*;

    itda_push_t push;
    logic       q_full;
    logic       q_valid;
    itda_job_t  q_job;
    logic       q_pop;

    itda_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .func     (func),
        .q_full   (q_full),
        .push     (push)
    );

    itda_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop)
    );

    itda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

### rtl/itda_checker.sv
// Port-level checker for int_to_decimal_ascii, bound to the top level.
`timescale 1ns / 1ps
`include "int_to_decimal_ascii_macros.svh"
module itda_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [itda_pkg::VALUE_IN_W-1:0] value,
    input logic                          func,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [itda_pkg::CHAR_W-1:0]   ascii_char,
    input logic                          last
);
    import itda_pkg::*;

    // high at the head of a text or right after its '-'
    logic head_reg;
    logic in_stall;
    logic out_stall;
    logic is_minus;
    logic is_zero;
    logic char_ok;

    assign in_stall  = in_valid && !in_ready;
    assign out_stall = out_valid && !out_ready;
    assign is_minus  = (ascii_char == CHAR_MINUS);
    assign is_zero   = (ascii_char == CHAR_ZERO);
    assign char_ok   = is_minus || (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + 8'd9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            head_reg <= last || is_minus;
        end
    end

    `ITDA_ASSERT(a_in_hold, in_stall |=> in_valid && $stable({value, func}), "input moved")
    `ITDA_ASSERT(a_out_hold, out_stall |=> out_valid && $stable({ascii_char, last}), "output moved")
    `ITDA_NEVER(a_bad_char, out_valid && !char_ok, "character is neither digit nor minus")
    `ITDA_NEVER(a_minus_last, out_valid && is_minus && last, "text ends in minus sign")
    `ITDA_NEVER(a_lead_zero, out_valid && head_reg && is_zero && !last, "leading zero emitted")

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);
